// ----- rtl/core/tfcc_pkg.sv -----
// ----------------------------------------------------------------------------
// tfcc_pkg: shared types and constants of the timed FSM coverage checker
// Item kinds, controller states and the command/status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package tfcc_pkg;

   localparam int STATES_DEF    = 64;
   localparam int INPUTS_DEF    = 16;
   localparam int TIME_BITS_DEF = 16;

   typedef enum logic [2:0] {
      KIND_LOAD_TRANS = 3'd0,
      KIND_LOAD_TMO   = 3'd1,
      KIND_MARK_TRANS = 3'd2,
      KIND_MARK_TMO   = 3'd3,
      KIND_STEP       = 3'd4,
      KIND_CLEAR      = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic clr_run;
      logic load;
      logic start;
      logic skip;
      logic check;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic resolved;
      logic hit_tmo;
      logic fire;
      logic rsp_free;
   } sts_type;

endpackage

// ----- rtl/core/tfcc_ctrl.sv -----
// ----------------------------------------------------------------------------
// tfcc_ctrl: controller of the timed FSM coverage checker
// Sequences mark clearing, table loads and the timeout walk of each step word.
// ----------------------------------------------------------------------------
module tfcc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [2:0]         req_kind,
   output logic               req_ready,
   input  tfcc_pkg::sts_type  sts,
   output tfcc_pkg::cmd_type  cmd
);

   tfcc_pkg::ctrl_state_type state_ff, state_in;
   logic is_step;
   logic is_clear;

   assign is_step  = (req_kind == tfcc_pkg::KIND_STEP);
   assign is_clear = (req_kind == tfcc_pkg::KIND_CLEAR);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tfcc_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tfcc_pkg::ST_CLEAR: begin
            if (sts.clr_last) state_in = tfcc_pkg::ST_IDLE;
         end
         tfcc_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (is_step && !sts.resolved) state_in = tfcc_pkg::ST_READ;
               else if (is_clear) state_in = tfcc_pkg::ST_CLEAR;
            end
         end
         tfcc_pkg::ST_READ: begin
            state_in = tfcc_pkg::ST_CHECK;
         end
         tfcc_pkg::ST_CHECK: begin
            if (!sts.hit_tmo && sts.fire) state_in = tfcc_pkg::ST_READ;
            else state_in = tfcc_pkg::ST_FINISH;
         end
         tfcc_pkg::ST_FINISH: begin
            if (sts.rsp_free) state_in = tfcc_pkg::ST_IDLE;
         end
         default: begin
            state_in = tfcc_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         tfcc_pkg::ST_CLEAR: begin
            cmd.clr_run = 1'b1;
         end
         tfcc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
            cmd.start = req_valid && is_step && !sts.resolved;
            cmd.skip  = req_valid && is_step && sts.resolved;
         end
         tfcc_pkg::ST_CHECK: begin
            cmd.check = 1'b1;
         end
         tfcc_pkg::ST_FINISH: begin
            cmd.finish = sts.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ----- rtl/core/tfcc_dp.sv -----
// ----------------------------------------------------------------------------
// tfcc_dp: datapath of the timed FSM coverage checker
// Table and mark memories, step time and state registers, result register.
// ----------------------------------------------------------------------------
module tfcc_dp #(
   parameter int STATES    = tfcc_pkg::STATES_DEF,
   parameter int INPUTS    = tfcc_pkg::INPUTS_DEF,
   parameter int TIME_BITS = tfcc_pkg::TIME_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  tfcc_pkg::cmd_type  cmd,
   output tfcc_pkg::sts_type  sts,
   input  logic [2:0]         req_kind,
   input  logic [5:0]         req_state_index,
   input  logic [3:0]         req_symbol,
   input  logic [5:0]         req_next_state,
   input  logic [15:0]        req_timeout_len,
   input  logic               req_mark,
   input  logic [15:0]        req_elapsed,
   input  logic               req_last,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic               rsp_covered
);

   localparam int SW    = (STATES > 1) ? $clog2(STATES) : 1;
   localparam int IW    = (INPUTS > 1) ? $clog2(INPUTS) : 1;
   localparam int TD    = STATES * INPUTS;
   localparam int AW    = $clog2(TD);
   localparam int TW    = TIME_BITS;

   logic [SW-1:0] nst_mem [TD];
   logic          tmk_mem [TD];
   logic [TW-1:0] olen_mem [STATES];
   logic [SW-1:0] otgt_mem [STATES];
   logic          omk_mem [STATES];

   logic [SW-1:0] nst_rd_ff;
   logic          tmk_rd_ff;
   logic [TW-1:0] olen_rd_ff;
   logic [SW-1:0] otgt_rd_ff;
   logic          omk_rd_ff;

   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [SW-1:0] cur_state_ff, cur_state_in;
   logic          resolved_ff, resolved_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_covered_ff, rsp_covered_in;

   logic [SW-1:0] s_work_ff, s_work_in;
   logic [TW-1:0] t_ff, t_in;
   logic [IW-1:0] sym_ff, sym_in;
   logic          sym_ok_ff, sym_ok_in;
   logic          last_ff, last_in;
   logic          first_ff, first_in;
   logic          hit_ff, hit_in;

   logic          st_ok, sym_ok, nxt_ok;
   logic [SW-1:0] ld_state;
   logic [SW-1:0] ld_next;
   logic [IW-1:0] ld_sym;
   logic [AW-1:0] ld_addr;
   logic [AW-1:0] rd_addr;
   logic [TW-1:0] ld_len;
   logic          fire;
   logic          hit_tmo;
   logic          rsp_free;
   logic          emit;

   assign st_ok    = (32'(req_state_index) < STATES);
   assign sym_ok   = (32'(req_symbol) < INPUTS);
   assign nxt_ok   = (32'(req_next_state) < STATES);
   assign ld_state = SW'(req_state_index);
   assign ld_next  = SW'(req_next_state);
   assign ld_sym   = IW'(req_symbol);
   assign ld_addr  = AW'(AW'(ld_state) * AW'(INPUTS)) + AW'(ld_sym);
   assign rd_addr  = AW'(AW'(s_work_ff) * AW'(INPUTS)) + AW'(sym_ff);
   assign ld_len   = (TW'(req_timeout_len) == '0) ? TW'(1) : TW'(req_timeout_len);

   // table memories
   always_ff @(posedge clock) begin
      if (cmd.load && (req_kind == tfcc_pkg::KIND_LOAD_TRANS) && st_ok && sym_ok && nxt_ok) begin
         nst_mem[ld_addr] <= ld_next;
      end
      nst_rd_ff <= nst_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load && (req_kind == tfcc_pkg::KIND_LOAD_TMO) && st_ok && nxt_ok) begin
         olen_mem[ld_state] <= ld_len;
         otgt_mem[ld_state] <= ld_next;
      end
      olen_rd_ff <= olen_mem[s_work_ff];
      otgt_rd_ff <= otgt_mem[s_work_ff];
   end

   // mark memories, swept to zero after reset and on a clear word
   always_ff @(posedge clock) begin
      if (cmd.clr_run) begin
         tmk_mem[clr_cnt_ff] <= 1'b0;
      end else if (cmd.load && (req_kind == tfcc_pkg::KIND_MARK_TRANS) && st_ok && sym_ok) begin
         tmk_mem[ld_addr] <= req_mark;
      end
      tmk_rd_ff <= tmk_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_run && (32'(clr_cnt_ff) < STATES)) begin
         omk_mem[clr_cnt_ff[SW-1:0]] <= 1'b0;
      end else if (cmd.load && (req_kind == tfcc_pkg::KIND_MARK_TMO) && st_ok) begin
         omk_mem[ld_state] <= req_mark;
      end
      omk_rd_ff <= omk_mem[s_work_ff];
   end

   assign fire     = (t_ff >= olen_rd_ff);
   assign hit_tmo  = omk_rd_ff && (first_ff ? (t_ff != '0) : fire);
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign emit     = cmd.finish && (hit_ff || last_ff);

   always_comb begin
      clr_cnt_in     = clr_cnt_ff;
      cur_state_in   = cur_state_ff;
      resolved_in    = resolved_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_covered_in = rsp_covered_ff;
      s_work_in      = s_work_ff;
      t_in           = t_ff;
      sym_in         = sym_ff;
      sym_ok_in      = sym_ok_ff;
      last_in        = last_ff;
      first_in       = first_ff;
      hit_in         = hit_ff;

      if (cmd.clr_run) begin
         clr_cnt_in = (clr_cnt_ff == AW'(TD - 1)) ? '0 : clr_cnt_ff + AW'(1);
      end

      if (cmd.start) begin
         s_work_in = cur_state_ff;
         t_in      = TW'(req_elapsed);
         sym_in    = ld_sym;
         sym_ok_in = sym_ok;
         last_in   = req_last;
         first_in  = 1'b1;
         hit_in    = 1'b0;
      end

      if (cmd.skip && req_last) begin
         cur_state_in = '0;
         resolved_in  = 1'b0;
      end

      if (cmd.check) begin
         first_in = 1'b0;
         if (hit_tmo) begin
            hit_in = 1'b1;
         end else if (fire) begin
            t_in      = t_ff - olen_rd_ff;
            s_work_in = otgt_rd_ff;
         end else if (sym_ok_ff) begin
            if (tmk_rd_ff) hit_in = 1'b1;
            else s_work_in = nst_rd_ff;
         end
      end

      if (cmd.finish) begin
         if (emit) begin
            rsp_valid_in   = 1'b1;
            rsp_covered_in = hit_ff;
         end
         if (hit_ff) resolved_in = 1'b1;
         else cur_state_in = s_work_ff;
         if (last_ff) begin
            cur_state_in = '0;
            resolved_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         cur_state_ff <= '0;
         resolved_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_cnt_ff   <= clr_cnt_in;
         cur_state_ff <= cur_state_in;
         resolved_ff  <= resolved_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_covered_ff <= rsp_covered_in;
      s_work_ff      <= s_work_in;
      t_ff           <= t_in;
      sym_ff         <= sym_in;
      sym_ok_ff      <= sym_ok_in;
      last_ff        <= last_in;
      first_ff       <= first_in;
      hit_ff         <= hit_in;
   end

   assign sts.clr_last = (clr_cnt_ff == AW'(TD - 1));
   assign sts.resolved = resolved_ff;
   assign sts.hit_tmo  = hit_tmo;
   assign sts.fire     = fire;
   assign sts.rsp_free = rsp_free;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_covered = rsp_covered_ff;

endmodule

// ----- rtl/core/timed_fsm_coverage_checker.sv -----
// ----------------------------------------------------------------------------
// timed_fsm_coverage_checker: timeout-aware FSM coverage checker
// A step word of an open sequence runs a table read and a check for each timeout
// fired and a last pair for the mark or transition check, then waits until a held
// result is taken; a result is emitted only when the step is covered or last. No
// new word is taken meanwhile; loads and steps of a resolved sequence one per cycle while idle.
// Reset and clear words sweep the mark memories with req_ready low; after reset
// the machine starts in state 0.
// ----------------------------------------------------------------------------
module timed_fsm_coverage_checker #(
   parameter int STATES    = tfcc_pkg::STATES_DEF,
   parameter int INPUTS    = tfcc_pkg::INPUTS_DEF,
   parameter int TIME_BITS = tfcc_pkg::TIME_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [5:0]  req_state_index,
   input  logic [3:0]  req_symbol,
   input  logic [5:0]  req_next_state,
   input  logic [15:0] req_timeout_len,
   input  logic        req_mark,
   input  logic [15:0] req_elapsed,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_covered
);

   tfcc_pkg::cmd_type cmd;
   tfcc_pkg::sts_type sts;

   tfcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tfcc_dp #(
      .STATES    (STATES),
      .INPUTS    (INPUTS),
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_kind        (req_kind),
      .req_state_index (req_state_index),
      .req_symbol      (req_symbol),
      .req_next_state  (req_next_state),
      .req_timeout_len (req_timeout_len),
      .req_mark        (req_mark),
      .req_elapsed     (req_elapsed),
      .req_last        (req_last),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_covered     (rsp_covered)
   );

endmodule

// ----- dv/tb_timed_fsm_coverage_checker.sv -----
// ----------------------------------------------------------------------------
// tb_timed_fsm_coverage_checker: self-checking bench of the FSM coverage checker
// Fills the next-state and timeout tables, then runs directed timeout-walk,
// transition-mark and ignored-word cases and a long run of random sequences.
// A behavioral copy of the timed FSM predicts every result word, and a
// checker compares each one as it is accepted.
// ----------------------------------------------------------------------------
module tb_timed_fsm_coverage_checker;

   localparam logic [2:0] KIND_SPARE_LO = 3'd6;
   localparam logic [2:0] KIND_SPARE_HI = 3'd7;
   localparam int MAX_FIRED       = 48;
   localparam int HOLD_CYCLES     = 600;
   localparam int DRAIN_CYCLES    = 300;
   localparam int WATCHDOG_CYCLES = 1000000;
   localparam int RANDOM_WORDS    = 450;
   localparam int FSM_STATES      = 16;
   localparam logic [5:0] TOP_STATE = 6'(FSM_STATES - 1);

   typedef struct packed {
      logic [2:0]  kind;
      logic [5:0]  state_index;
      logic [3:0]  symbol;
      logic [5:0]  next_state;
      logic [15:0] timeout_len;
      logic        mark;
      logic [15:0] elapsed;
      logic        last;
   } req_word_type;

   typedef enum int {STALL_NONE, STALL_COIN, STALL_SPARSE, STALL_PATTERN} stall_mode_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_kind;
   logic [5:0]  req_state_index;
   logic [3:0]  req_symbol;
   logic [5:0]  req_next_state;
   logic [15:0] req_timeout_len;
   logic        req_mark;
   logic [15:0] req_elapsed;
   logic        req_last;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_covered;

   logic [5:0]  fsm_next   [1024];
   logic [15:0] tmo_len    [64];
   logic [5:0]  tmo_target [64];
   bit          trans_mark [1024];
   bit          tmo_mark   [64];
   logic [5:0]  fsm_state;
   bit          seq_resolved;

   bit expected_covered[$];
   bit want_covered;
   int mismatch_count;
   int burst_left;
   bit hold_rsp;

   timed_fsm_coverage_checker uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_state_index (req_state_index),
      .req_symbol      (req_symbol),
      .req_next_state  (req_next_state),
      .req_timeout_len (req_timeout_len),
      .req_mark        (req_mark),
      .req_elapsed     (req_elapsed),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_covered     (rsp_covered)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit walk_fsm_step(input logic [15:0] el, input logic [3:0] sym,
                                        output logic [5:0] end_state, output int fired);
      logic [5:0] s;
      int unsigned t;
      s = fsm_state;
      t = 32'(el);
      fired = 0;
      end_state = fsm_state;
      if (tmo_mark[s] && t >= 1) return 1'b1;
      while (t >= 32'(tmo_len[s])) begin
         if (tmo_mark[s]) return 1'b1;
         t -= 32'(tmo_len[s]);
         s = tmo_target[s];
         fired++;
      end
      if (trans_mark[{s, sym}]) return 1'b1;
      end_state = fsm_next[{s, sym}];
      return 1'b0;
   endfunction

   function automatic void advance_fsm_model(input req_word_type w);
      logic [5:0] end_state;
      int fired;
      case (w.kind)
         tfcc_pkg::KIND_LOAD_TRANS: fsm_next[{w.state_index, w.symbol}] = w.next_state;
         tfcc_pkg::KIND_LOAD_TMO: begin
            tmo_len[w.state_index] = (w.timeout_len == 16'd0) ? 16'd1 : w.timeout_len;
            tmo_target[w.state_index] = w.next_state;
         end
         tfcc_pkg::KIND_MARK_TRANS: trans_mark[{w.state_index, w.symbol}] = w.mark;
         tfcc_pkg::KIND_MARK_TMO: tmo_mark[w.state_index] = w.mark;
         tfcc_pkg::KIND_STEP: begin
            if (!seq_resolved) begin
               if (walk_fsm_step(w.elapsed, w.symbol, end_state, fired)) begin
                  expected_covered.push_back(1'b1);
                  seq_resolved = 1'b1;
               end else begin
                  fsm_state = end_state;
                  if (w.last) expected_covered.push_back(1'b0);
               end
            end
            if (w.last) begin
               fsm_state = 6'd0;
               seq_resolved = 1'b0;
            end
         end
         tfcc_pkg::KIND_CLEAR: begin
            foreach (trans_mark[i]) trans_mark[i] = 1'b0;
            foreach (tmo_mark[i]) tmo_mark[i] = 1'b0;
         end
         default: ;
      endcase
   endfunction

   function automatic req_word_type word_of_kind(input logic [2:0] kind);
      req_word_type w;
      w.kind = kind;
      w.state_index = 6'($urandom);
      w.symbol = 4'($urandom);
      w.next_state = 6'($urandom);
      w.timeout_len = 16'($urandom);
      w.mark = 1'($urandom);
      w.elapsed = 16'($urandom);
      w.last = 1'($urandom);
      return w;
   endfunction

   // shrink elapsed until the timeout walk stays short
   function automatic req_word_type step_word(input logic [3:0] sym, input logic [15:0] el,
                                              input logic last);
      req_word_type w;
      logic [5:0] end_state;
      int fired;
      w = word_of_kind(tfcc_pkg::KIND_STEP);
      w.symbol = sym;
      w.last = last;
      if (!seq_resolved) begin
         void'(walk_fsm_step(el, sym, end_state, fired));
         while (fired > MAX_FIRED) begin
            el = el >> 1;
            void'(walk_fsm_step(el, sym, end_state, fired));
         end
      end
      w.elapsed = el;
      return w;
   endfunction

   task automatic send_word(input req_word_type w);
      int gap;
      if (burst_left == 0) begin
         burst_left = int'($urandom_range(1, 24));
         gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 8));
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_kind <= w.kind;
      req_state_index <= w.state_index;
      req_symbol <= w.symbol;
      req_next_state <= w.next_state;
      req_timeout_len <= w.timeout_len;
      req_mark <= w.mark;
      req_elapsed <= w.elapsed;
      req_last <= w.last;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      advance_fsm_model(w);
   endtask

   task automatic send_load_tmo(input logic [5:0] st, input logic [15:0] len,
                                input logic [5:0] target);
      req_word_type w;
      w = word_of_kind(tfcc_pkg::KIND_LOAD_TMO);
      w.state_index = st;
      w.timeout_len = len;
      w.next_state = target;
      send_word(w);
   endtask

   task automatic send_mark(input logic [2:0] kind, input logic [5:0] st,
                            input logic [3:0] sym, input logic mk);
      req_word_type w;
      w = word_of_kind(kind);
      w.state_index = st;
      w.symbol = sym;
      w.mark = mk;
      send_word(w);
   endtask

   function automatic logic [5:0] random_fsm_state();
      return 6'($urandom_range(0, FSM_STATES - 1));
   endfunction

   function automatic req_word_type random_table_word();
      req_word_type w;
      int pick;
      pick = int'($urandom_range(0, 99));
      if (pick < 35) w = word_of_kind(tfcc_pkg::KIND_LOAD_TRANS);
      else if (pick < 60) w = word_of_kind(tfcc_pkg::KIND_LOAD_TMO);
      else if (pick < 85) w = word_of_kind(tfcc_pkg::KIND_MARK_TRANS);
      else w = word_of_kind(tfcc_pkg::KIND_MARK_TMO);
      w.state_index = random_fsm_state();
      w.next_state = random_fsm_state();
      if (w.kind == tfcc_pkg::KIND_LOAD_TMO && $urandom_range(0, 3) == 0)
         w.timeout_len = 16'($urandom_range(0, 15));
      if (w.kind == tfcc_pkg::KIND_MARK_TRANS || w.kind == tfcc_pkg::KIND_MARK_TMO) begin
         w.mark = ($urandom_range(0, 9) < 3);
         if ($urandom_range(0, 2) == 0) w.state_index = fsm_state;
      end
      return w;
   endfunction

   function automatic logic [15:0] random_elapsed();
      case ($urandom_range(0, 3))
         0: return 16'd0;
         1: return 16'($urandom_range(1, 15));
         2: return 16'($urandom_range(0, 1023));
         default: return 16'($urandom);
      endcase
   endfunction

   // noise: spare kinds, a clear, or an extra step that may end the sequence early
   task automatic send_noise(inout int sent);
      int pick;
      pick = int'($urandom_range(0, 2));
      if (pick == 0) begin
         send_word(word_of_kind($urandom_range(0, 1) ? KIND_SPARE_LO : KIND_SPARE_HI));
      end else if (pick == 1) begin
         send_word(word_of_kind(tfcc_pkg::KIND_CLEAR));
         sent++;
      end else begin
         send_word(step_word(4'($urandom), random_elapsed(), 1'($urandom)));
         sent++;
      end
   endtask

   task automatic test_table_fill();
      req_word_type w;
      for (int s = 0; s < FSM_STATES; s++) begin
         if (s == 0) send_load_tmo(6'(s), 16'd0, random_fsm_state());
         else if (s == FSM_STATES - 1) send_load_tmo(6'(s), 16'hFFFF, random_fsm_state());
         else if ($urandom_range(0, 3) == 0)
            send_load_tmo(6'(s), 16'($urandom_range(0, 15)), random_fsm_state());
         else send_load_tmo(6'(s), 16'($urandom), random_fsm_state());
      end
      for (int i = 0; i < FSM_STATES * 16; i++) begin
         w = word_of_kind(tfcc_pkg::KIND_LOAD_TRANS);
         w.state_index = i[9:4];
         w.symbol = i[3:0];
         w.next_state = random_fsm_state();
         send_word(w);
      end
   endtask

   task automatic test_timeout_walk();
      send_load_tmo(6'd0, 16'd0, TOP_STATE);
      send_load_tmo(TOP_STATE, 16'd0, 6'd0);
      send_mark(tfcc_pkg::KIND_MARK_TMO, TOP_STATE, 4'd0, 1'b1);
      send_word(step_word(4'd15, 16'hFFFF, 1'b0));
      send_word(step_word(4'd0, 16'd0, 1'b0));
      send_word(step_word(4'd0, 16'd0, 1'b1));
      send_load_tmo(TOP_STATE, 16'hFFFF, 6'd0);
      send_mark(tfcc_pkg::KIND_MARK_TMO, TOP_STATE, 4'd0, 1'b0);
      send_word(step_word(4'd15, 16'd1, 1'b1));
      send_mark(tfcc_pkg::KIND_MARK_TMO, 6'd0, 4'd0, 1'b1);
      send_word(step_word(4'd0, 16'd1, 1'b1));
      send_word(step_word(4'd0, 16'd0, 1'b1));
      send_mark(tfcc_pkg::KIND_MARK_TMO, 6'd0, 4'd0, 1'b0);
   endtask

   task automatic test_transition_marks();
      send_mark(tfcc_pkg::KIND_MARK_TRANS, 6'd0, 4'd15, 1'b1);
      send_word(step_word(4'd15, 16'd0, 1'b1));
      send_mark(tfcc_pkg::KIND_MARK_TRANS, 6'd0, 4'd15, 1'b0);
      send_word(step_word(4'd15, 16'd0, 1'b1));
      send_mark(tfcc_pkg::KIND_MARK_TRANS, 6'd0, 4'd3, 1'b1);
      send_word(step_word(4'd3, 16'd0, 1'b0));
      send_word(word_of_kind(tfcc_pkg::KIND_CLEAR));
      send_word(step_word(4'd3, 16'd0, 1'b1));
      send_word(step_word(4'd3, 16'd0, 1'b1));
   endtask

   task automatic test_ignored_words();
      send_word(word_of_kind(KIND_SPARE_LO));
      send_word(word_of_kind(KIND_SPARE_HI));
      send_word(step_word(4'd1, 16'd0, 1'b0));
      send_word(word_of_kind(KIND_SPARE_HI));
      send_word(step_word(4'd2, 16'd0, 1'b1));
   endtask

   task automatic test_random_traffic(input int words);
      int sent;
      int seq_len;
      bit hold_done;
      sent = 0;
      hold_done = 1'b0;
      while (sent < words) begin
         if (!hold_done && sent >= words / 2) begin
            hold_rsp = 1'b1;
            hold_done = 1'b1;
         end
         repeat ($urandom_range(0, 4)) begin
            send_word(random_table_word());
            sent++;
         end
         seq_len = int'($urandom_range(1, 8));
         for (int i = 0; i < seq_len; i++) begin
            if ($urandom_range(0, 3) == 0) begin
               send_word(random_table_word());
               sent++;
            end
            if ($urandom_range(0, 15) == 0) send_noise(sent);
            send_word(step_word(4'($urandom), random_elapsed(), i == seq_len - 1));
            sent++;
         end
      end
   endtask

   task automatic wait_results_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_covered.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : rsp_stall_pattern
      stall_mode_type mode;
      int left;
      int tick;
      rsp_ready = 1'b0;
      mode = STALL_NONE;
      left = 0;
      tick = 0;
      forever begin
         @(negedge clock);
         tick++;
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end else begin
            if (left == 0) begin
               mode = stall_mode_type'($urandom_range(0, 3));
               left = int'($urandom_range(8, 96));
            end
            left--;
            case (mode)
               STALL_NONE: rsp_ready <= 1'b1;
               STALL_COIN: rsp_ready <= ($urandom_range(0, 1) == 1);
               STALL_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= (tick % 7 < 4);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (expected_covered.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual covered=%0b",
                     $time, rsp_covered);
            mismatch_count++;
         end else begin
            want_covered = expected_covered.pop_front();
            if (rsp_covered !== want_covered) begin
               $display("%0t: covered mismatch, expected %0b, actual %0b",
                        $time, want_covered, rsp_covered);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      repeat (WATCHDOG_CYCLES) @(posedge clock);
      $display("simulation failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = tfcc_pkg::KIND_STEP;
      req_state_index = '0;
      req_symbol = '0;
      req_next_state = '0;
      req_timeout_len = '0;
      req_mark = 1'b0;
      req_elapsed = '0;
      req_last = 1'b0;
      fsm_state = 6'd0;
      seq_resolved = 1'b0;
      mismatch_count = 0;
      burst_left = 0;
      hold_rsp = 1'b0;
      foreach (trans_mark[i]) trans_mark[i] = 1'b0;
      foreach (tmo_mark[i]) tmo_mark[i] = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_table_fill();
      test_timeout_walk();
      test_transition_marks();
      test_ignored_words();
      test_random_traffic(RANDOM_WORDS);
      wait_results_drained();
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
